// ===== hw/rtl/complex_arith_unit_macros.svh =====
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_MACROS_SVH
`define COMPLEX_ARITH_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("complex_arith_unit: assertion failed");

// Check that cons holds in the cycle after ante.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("complex_arith_unit: assertion failed");

`endif

// ===== hw/rtl/cau_pkg.sv =====
// Shared codes and field layout of the complex arithmetic unit.
package cau_pkg;

	localparam int FIELD_W = 32;
	localparam int ACT_W = 2;
	localparam int ST_W = 2;

	localparam int IN_AR_LSB = ACT_W;
	localparam int IN_AI_LSB = IN_AR_LSB + FIELD_W;
	localparam int IN_BR_LSB = IN_AI_LSB + FIELD_W;
	localparam int IN_BI_LSB = IN_BR_LSB + FIELD_W;
	localparam int IN_BITS = IN_BI_LSB + FIELD_W;
	localparam int IN_BYTES_W = ((IN_BITS + 7) / 8) * 8;

	localparam int OUT_BITS = 2 * FIELD_W + ST_W;
	localparam int OUT_BYTES_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int PROD_W = 64;
	localparam int SUM_W = PROD_W + 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD = 2'd0,
		ACT_SUB = 2'd1,
		ACT_MUL = 2'd2,
		ACT_DIV = 2'd3
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

endpackage

// ===== hw/rtl/complex_arith_unit.sv =====
// Complex add, subtract, multiply and divide in signed fixed point, fully pipelined.
//
// Input stream s_axis: one beat carries an action code and operands a and b.
// Output stream m_axis: one beat per input beat, in order, with the result
// parts and a status (ok, saturated, divide by zero).
// Every action takes the same path: the product register, the sums and saturation
// register, 64 + F division cells (one quotient bit per cell, real and imaginary
// lanes side by side), and one output register. Add, subtract and multiply results
// ride along the division chain so all results leave in order.
// Throughput is one beat per cycle while the receiver does not stall; the
// division cell row sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_axis_tready drops; it stays high while the output register is empty or taken.
// Reset clears all valid flags; no result is pending after reset.
// F is FRAC_BITS clamped to 1..W-1, W is DATA_WIDTH clamped to 2..32.
`include "complex_arith_unit_macros.svh"

module complex_arith_unit
	import cau_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// action, a_re, a_im, b_re, b_im (lowest bit up)
	input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// res_re, res_im, status (lowest bit up)
	output logic [OUT_BYTES_W-1:0] m_axis_tdata
);

	localparam int W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
	localparam int F = (FRAC_BITS < 1) ? 1 : ((FRAC_BITS > W - 1) ? W - 1 : FRAC_BITS);
	localparam int NSTEP = 64 + F;
	localparam logic signed [SUM_W-1:0] SAT_HI = (66'sd1 <<< (W - 1)) - 66'sd1;
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - 66'sd1;
	localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic         vld;
		logic         is_div;
		logic         dz;
		logic         hit;
		logic         neg_re;
		logic         neg_im;
		logic [W-1:0] re;
		logic [W-1:0] im;
	} side_t;

	logic en;

	logic signed [W-1:0] ar_w, ai_w, br_w, bi_w;
	action_t act_in;

	logic                     vld_s1;
	action_t                  act_s1;
	logic signed [W-1:0]      ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PROD_W-1:0] rr_s1, ii_s1, ri_s1, ir_s1, brr_s1, bii_s1;

	logic signed [SUM_W-1:0] sum_re, sum_im;
	logic                    neg_re, neg_im, hit_re, hit_im;
	logic [SUM_W-1:0]        abs_re, abs_im;
	logic [W-1:0]            sat_re, sat_im;
	logic [63:0]             den_nx;

	side_t       side_q [NSTEP+1];
	logic [63:0] mag_s2 [2];
	logic [63:0] den_s2;

	logic [63:0]  den_c [2][NSTEP+1];
	logic [63:0]  rem_c [2][NSTEP+1];
	logic [63:0]  dvd_c [2][NSTEP+1];
	logic [W-1:0] q_c   [2][NSTEP+1];
	logic         ovf_c [2][NSTEP+1];

	logic [W-1:0]    lane_val [2];
	logic [1:0]      lane_hit;
	logic [W-1:0]    lim [2];
	logic [W-1:0]    lmag [2];
	logic [W:0]      lneg [2];

	logic signed [W-1:0] fin_re, fin_im;
	status_t             fin_st;

	logic                out_vld_q;
	logic [FIELD_W-1:0]  out_re_q, out_im_q;
	status_t             out_st_q;

	logic [NSTEP+1:0] vld_vec;

	assign en = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	assign act_in = action_t'(s_axis_tdata[ACT_W-1:0]);
	assign ar_w = s_axis_tdata[IN_AR_LSB +: W];
	assign ai_w = s_axis_tdata[IN_AI_LSB +: W];
	assign br_w = s_axis_tdata[IN_BR_LSB +: W];
	assign bi_w = s_axis_tdata[IN_BI_LSB +: W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1 <= act_in;
			ar_s1 <= ar_w;
			ai_s1 <= ai_w;
			br_s1 <= br_w;
			bi_s1 <= bi_w;
			rr_s1 <= PROD_W'(ar_w) * PROD_W'(br_w);
			ii_s1 <= PROD_W'(ai_w) * PROD_W'(bi_w);
			ri_s1 <= PROD_W'(ar_w) * PROD_W'(bi_w);
			ir_s1 <= PROD_W'(ai_w) * PROD_W'(br_w);
			brr_s1 <= PROD_W'(br_w) * PROD_W'(br_w);
			bii_s1 <= PROD_W'(bi_w) * PROD_W'(bi_w);
		end
	end

	always_comb begin
		case (act_s1)
			ACT_ADD: begin
				sum_re = SUM_W'(ar_s1) + SUM_W'(br_s1);
				sum_im = SUM_W'(ai_s1) + SUM_W'(bi_s1);
			end
			ACT_SUB: begin
				sum_re = SUM_W'(ar_s1) - SUM_W'(br_s1);
				sum_im = SUM_W'(ai_s1) - SUM_W'(bi_s1);
			end
			ACT_MUL: begin
				sum_re = SUM_W'(rr_s1 >>> F) - SUM_W'(ii_s1 >>> F);
				sum_im = SUM_W'(ri_s1 >>> F) + SUM_W'(ir_s1 >>> F);
			end
			default: begin
				sum_re = SUM_W'(rr_s1) + SUM_W'(ii_s1);
				sum_im = SUM_W'(ir_s1) - SUM_W'(ri_s1);
			end
		endcase
		neg_re = sum_re < 0;
		neg_im = sum_im < 0;
		abs_re = neg_re ? SUM_W'(-sum_re) : SUM_W'(sum_re);
		abs_im = neg_im ? SUM_W'(-sum_im) : SUM_W'(sum_im);
		hit_re = (sum_re > SAT_HI) || (sum_re < SAT_LO);
		hit_im = (sum_im > SAT_HI) || (sum_im < SAT_LO);
		sat_re = hit_re ? (neg_re ? LIM_NEG : LIM_POS) : sum_re[W-1:0];
		sat_im = hit_im ? (neg_im ? LIM_NEG : LIM_POS) : sum_im[W-1:0];
		den_nx = 64'(brr_s1) + 64'(bii_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q[0] <= '0;
		end else if (en) begin
			side_q[0].vld <= vld_s1;
			side_q[0].is_div <= act_s1 == ACT_DIV;
			side_q[0].dz <= den_nx == 64'd0;
			side_q[0].hit <= hit_re || hit_im;
			side_q[0].neg_re <= neg_re;
			side_q[0].neg_im <= neg_im;
			side_q[0].re <= sat_re;
			side_q[0].im <= sat_im;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2[0] <= abs_re[63:0];
			mag_s2[1] <= abs_im[63:0];
			den_s2 <= den_nx;
		end
	end

	genvar l, k;
	generate
		for (l = 0; l < 2; l++) begin : g_lane
			assign den_c[l][0] = den_s2;
			assign rem_c[l][0] = '0;
			assign dvd_c[l][0] = mag_s2[l];
			assign q_c[l][0] = '0;
			assign ovf_c[l][0] = 1'b0;
			for (k = 0; k < NSTEP; k++) begin : g_cell
				cau_div_cell #(
					.QW(W)
				) u_cell (
					.clk    (clk),
					.en     (en),
					.den_in (den_c[l][k]),
					.rem_in (rem_c[l][k]),
					.dvd_in (dvd_c[l][k]),
					.q_in   (q_c[l][k]),
					.ovf_in (ovf_c[l][k]),
					.den_out(den_c[l][k+1]),
					.rem_out(rem_c[l][k+1]),
					.dvd_out(dvd_c[l][k+1]),
					.q_out  (q_c[l][k+1]),
					.ovf_out(ovf_c[l][k+1])
				);
			end
		end
		for (k = 0; k < NSTEP; k++) begin : g_side
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					side_q[k+1] <= '0;
				end else if (en) begin
					side_q[k+1] <= side_q[k];
				end
			end
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			if (i == 0) begin
				lim[i] = side_q[NSTEP].neg_re ? LIM_NEG : LIM_POS;
			end else begin
				lim[i] = side_q[NSTEP].neg_im ? LIM_NEG : LIM_POS;
			end
			lane_hit[i] = ovf_c[i][NSTEP] || (q_c[i][NSTEP] > lim[i]);
			lmag[i] = lane_hit[i] ? lim[i] : q_c[i][NSTEP];
			lneg[i] = -{1'b0, lmag[i]};
		end
		lane_val[0] = side_q[NSTEP].neg_re ? lneg[0][W-1:0] : lmag[0];
		lane_val[1] = side_q[NSTEP].neg_im ? lneg[1][W-1:0] : lmag[1];

		if (side_q[NSTEP].is_div) begin
			if (side_q[NSTEP].dz) begin
				fin_re = '0;
				fin_im = '0;
				fin_st = ST_DZ;
			end else begin
				fin_re = lane_val[0];
				fin_im = lane_val[1];
				fin_st = (|lane_hit) ? ST_SAT : ST_OK;
			end
		end else begin
			fin_re = side_q[NSTEP].re;
			fin_im = side_q[NSTEP].im;
			fin_st = side_q[NSTEP].hit ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= side_q[NSTEP].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_re_q <= FIELD_W'(fin_re);
			out_im_q <= FIELD_W'(fin_im);
			out_st_q <= fin_st;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = {{(OUT_BYTES_W - OUT_BITS){1'b0}}, out_st_q, out_im_q, out_re_q};

	always_comb begin
		vld_vec[0] = vld_s1;
		for (int i = 0; i < NSTEP; i++) begin
			vld_vec[i+1] = side_q[i].vld;
		end
		vld_vec[NSTEP+1] = out_vld_q;
	end

	`CAU_ASSERT_IMP(a_dz_zero, out_vld_q && (out_st_q == ST_DZ), (out_re_q == '0) && (out_im_q == '0))
	`CAU_ASSERT_IMP(a_sat_extreme, out_vld_q && (out_st_q == ST_SAT), (out_re_q == 32'(SAT_HI)) || (out_re_q == 32'(SAT_LO)) || (out_im_q == 32'(SAT_HI)) || (out_im_q == 32'(SAT_LO)))
	`CAU_ASSERT_NXT(a_stall_hold, !en, $stable(vld_vec))

endmodule

// ===== hw/rtl/cau_div_cell.sv =====
// One restoring-division step: shift in a dividend bit, trial subtract, emit a quotient bit.
module cau_div_cell #(
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [63:0]   den_in,
	input  logic [63:0]   rem_in,
	input  logic [63:0]   dvd_in,
	input  logic [QW-1:0] q_in,
	input  logic          ovf_in,
	output logic [63:0]   den_out,
	output logic [63:0]   rem_out,
	output logic [63:0]   dvd_out,
	output logic [QW-1:0] q_out,
	output logic          ovf_out
);

	logic [64:0] trial;
	logic [64:0] diff;
	logic        ge;
	logic [63:0] rem_nx;

	always_comb begin
		trial = {rem_in, dvd_in[63]};
		diff = trial - {1'b0, den_in};
		ge = trial >= {1'b0, den_in};
		rem_nx = ge ? diff[63:0] : trial[63:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_out <= den_in;
			rem_out <= rem_nx;
			dvd_out <= {dvd_in[62:0], 1'b0};
			q_out <= {q_in[QW-2:0], ge};
			ovf_out <= ovf_in | q_in[QW-1];
		end
	end

endmodule

// ===== sim/complex_arith_unit_tb.sv =====
// Self-checking testbench for the complex arithmetic unit: directed, random and backpressure runs.
module complex_arith_unit_tb;
	import cau_pkg::*;

	localparam int TIMEOUT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 200;
	localparam int FB = 16;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		status_t            status;
	} cplx_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// action, a_re, a_im, b_re, b_im (lowest bit up)
	logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// res_re, res_im, status (lowest bit up)
	logic [OUT_BYTES_W-1:0] m_axis_tdata;

	cplx_result_t pending_results[$];
	int           errors = 0;
	int           cycles = 0;
	int           results_seen = 0;
	int           act_count[4] = '{0, 0, 0, 0};
	int           sat_count = 0;
	int           dz_count = 0;
	bit           long_hold_req = 1'b0;
	bit           long_hold_done = 1'b0;
	int           hold_left = 0;
	int           stall_left = 0;
	bit           gaps_on = 1'b1;

	complex_arith_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic signed [31:0] clamp32(longint v, inout bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1'b1;
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			hit = 1'b1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// Quotient (num * 2^F) / den, truncated toward zero, then clamped.
	function automatic logic signed [31:0] fixed_quotient(logic signed [127:0] num,
			logic [127:0] den, inout bit hit);
		logic [127:0] mag;
		logic [127:0] q;
		logic [127:0] lim;
		bit           neg;
		neg = num < 0;
		mag = neg ? -num : num;
		q = (mag << FB) / den;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) begin
			hit = 1'b1;
			q = lim;
		end
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic cplx_result_t complex_result(action_t act, logic signed [31:0] a_re,
			logic signed [31:0] a_im, logic signed [31:0] b_re, logic signed [31:0] b_im);
		cplx_result_t        r;
		longint              ar, ai, br, bi;
		logic signed [127:0] num_re, num_im;
		logic [127:0]        den;
		bit                  hit;
		ar = a_re; ai = a_im; br = b_re; bi = b_im;
		hit = 1'b0;
		r.res_re = '0;
		r.res_im = '0;
		r.status = ST_OK;
		case (act)
			ACT_ADD: begin
				r.res_re = clamp32(ar + br, hit);
				r.res_im = clamp32(ai + bi, hit);
			end
			ACT_SUB: begin
				r.res_re = clamp32(ar - br, hit);
				r.res_im = clamp32(ai - bi, hit);
			end
			ACT_MUL: begin
				r.res_re = clamp32(((ar * br) >>> FB) - ((ai * bi) >>> FB), hit);
				r.res_im = clamp32(((ar * bi) >>> FB) + ((ai * br) >>> FB), hit);
			end
			default: begin
				den = 128'(br * br) + 128'(bi * bi);
				if (den == 0) begin
					r.status = ST_DZ;
				end else begin
					num_re = 128'(signed'(ar * br)) + 128'(signed'(ai * bi));
					num_im = 128'(signed'(ai * br)) - 128'(signed'(ar * bi));
					r.res_re = fixed_quotient(num_re, den, hit);
					r.res_im = fixed_quotient(num_im, den, hit);
				end
			end
		endcase
		if (r.status == ST_OK && hit)
			r.status = ST_SAT;
		return r;
	endfunction

	task automatic send_beat(action_t act, logic [31:0] a_re, logic [31:0] a_im,
			logic [31:0] b_re, logic [31:0] b_im);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, b_im, b_re, a_im, a_re, act};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_results.push_back(complex_result(act, a_re, a_im, b_re, b_im));
		act_count[act]++;
		gap = 0;
		if (gaps_on && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 5))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					3: return 32'hffff_ffff;
					4: return 32'h0001_0000;
					default: return 32'hffff_0000;
				endcase
			end
			1, 2, 3: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0010_0000)
				: -$urandom_range(0, 32'h0010_0000);
			4, 5: return $urandom_range(0, 1) ? $urandom_range(0, 32'h00ff_ffff)
				: -$urandom_range(0, 32'h00ff_ffff);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_beat();
		action_t     act;
		logic [31:0] b_re, b_im;
		act = action_t'($urandom_range(0, 3));
		b_re = pick_operand();
		b_im = pick_operand();
		if (act == ACT_DIV && $urandom_range(0, 15) == 0) begin
			b_re = '0;
			b_im = '0;
		end
		send_beat(act, pick_operand(), pick_operand(), b_re, b_im);
	endtask

	task automatic test_directed();
		send_beat(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
		send_beat(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(ACT_ADD, 32'h0001_0000, 32'h0002_0000, 32'hfffe_0000, 32'h0000_8000);
		send_beat(ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_ffff);
		send_beat(ACT_SUB, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff);
		send_beat(ACT_SUB, 32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 32'h8765_4321);
		send_beat(ACT_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_beat(ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		send_beat(ACT_MUL, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
		send_beat(ACT_MUL, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001, 32'hffff_ffff);
		send_beat(ACT_MUL, 32'h0003_8000, 32'hfffe_4000, 32'hffff_c000, 32'h0002_2000);
		send_beat(ACT_DIV, 32'h0005_0000, 32'h0007_0000, 32'h0000_0000, 32'h0000_0000);
		send_beat(ACT_DIV, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
		send_beat(ACT_DIV, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
		send_beat(ACT_DIV, 32'hffff_0000, 32'h0000_0000, 32'h0003_0000, 32'h0000_0000);
		send_beat(ACT_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
		send_beat(ACT_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_beat(ACT_DIV, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_beat(ACT_DIV, 32'h0002_0000, 32'hfffd_0000, 32'hffff_0000, 32'h0001_0000);
		send_beat(ACT_DIV, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
	endtask

	task automatic test_random(int count);
		repeat (count) random_beat();
	endtask

	task automatic test_backpressure();
		long_hold_req = 1'b1;
		gaps_on = 1'b0;
		repeat (150) random_beat();
		wait (long_hold_done);
		long_hold_req = 1'b0;
		gaps_on = 1'b1;
	endtask

	// Sink: random stalls, plus one long hold on request.
	always @(posedge clk) begin
		if (long_hold_req && !long_hold_done && hold_left == 0 && m_axis_tvalid) begin
			hold_left <= 400;
			long_hold_done <= 1'b1;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= (hold_left == 1);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= (stall_left == 1);
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
				: $urandom_range(1, 3);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cplx_result_t want;
		cplx_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[31:0], m_axis_tdata[63:32], status_t'(m_axis_tdata[65:64])};
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("unexpected result beat re=%h im=%h status=%0d",
					got.res_re, got.res_im, got.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.res_re !== want.res_re) begin
					$error("res_re expected %h actual %h", want.res_re, got.res_re);
					errors++;
				end
				if (got.res_im !== want.res_im) begin
					$error("res_im expected %h actual %h", want.res_im, got.res_im);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status);
					errors++;
				end
				if (want.status == ST_SAT)
					sat_count++;
				if (want.status == ST_DZ)
					dz_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(250);
		test_backpressure();
		test_random(250);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() > 0)
			errors++;
		$display("Ran %0d add, %0d sub, %0d mul, %0d div beats; %0d results checked.",
			act_count[ACT_ADD], act_count[ACT_SUB], act_count[ACT_MUL], act_count[ACT_DIV],
			results_seen);
		$display("Saturated results: %0d, divide-by-zero results: %0d, errors: %0d.",
			sat_count, dz_count, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
